### sv/cbw_pkg.sv
// shared types, widths and codes for the confined barycentric weights block
package cbw_pkg;

    localparam int COORD_BITS       = 24;
    localparam int COORD_FRAC_BITS  = 12;
    localparam int WEIGHT_FRAC_BITS = 16;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int HALF_W = DOT_W / 2;
    localparam int WIDE_W = 2 * DOT_W;
    localparam int WT_W   = WEIGHT_FRAC_BITS + 1;
    localparam int NDOT   = 8;

    localparam int DOT_S11 = 0;
    localparam int DOT_S12 = 1;
    localparam int DOT_S22 = 2;
    localparam int DOT_T1  = 3;
    localparam int DOT_T2  = 4;
    localparam int DOT_DA  = 5;
    localparam int DOT_DB  = 6;
    localparam int DOT_DC  = 7;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;
    typedef logic signed [DOT_W-1:0]      dot_t;
    typedef logic [DOT_W-1:0]             dmag_t;
    typedef logic [2*HALF_W-1:0]          pp_t;
    typedef logic signed [WIDE_W-1:0]     wide_t;
    typedef logic [WIDE_W-1:0]            mag_t;
    typedef logic [WT_W-1:0]              weight_t;
    typedef logic [NDOT-1:0][DOT_W-1:0]   dot_set_t;

    localparam weight_t WT_ONE = WT_W'(1) << WEIGHT_FRAC_BITS;

    // det * 100000 < 2^(4*frac)  <=>  det <= floor((2^(4*frac) - 1) / 100000)
    localparam mag_t DEGEN_RECIP = WIDE_W'(100000);
    localparam mag_t DEGEN_POW   = WIDE_W'(1) << (4 * COORD_FRAC_BITS);
    localparam mag_t DEGEN_LIMIT = (DEGEN_POW - WIDE_W'(1)) / DEGEN_RECIP;

    typedef enum logic [2:0] {
        REG_INSIDE  = 3'd0,
        REG_EDGE_BC = 3'd1,
        REG_EDGE_AC = 3'd2,
        REG_EDGE_AB = 3'd3,
        REG_VERT_A  = 3'd4,
        REG_VERT_B  = 3'd5,
        REG_VERT_C  = 3'd6,
        REG_DEGEN   = 3'd7
    } region_t;

    typedef struct packed {
        logic a_wins;
        logic b_wins;
    } near_t;

    typedef struct packed {
        coord_t point_x;
        coord_t point_y;
        coord_t point_z;
        coord_t corner_a_x;
        coord_t corner_a_y;
        coord_t corner_a_z;
        coord_t corner_b_x;
        coord_t corner_b_y;
        coord_t corner_b_z;
        coord_t corner_c_x;
        coord_t corner_c_y;
        coord_t corner_c_z;
    } in_item_t;

    typedef struct packed {
        weight_t weight_a;
        weight_t weight_b;
        weight_t weight_c;
        region_t region;
    } out_item_t;

    typedef struct packed {
        region_t region;
        weight_t fix_a;
        weight_t fix_b;
        weight_t fix_c;
    } side_t;

    typedef struct packed {
        mag_t  num0;
        mag_t  num1;
        mag_t  den;
        side_t side;
    } div_req_t;

    typedef struct packed {
        weight_t quot0;
        weight_t quot1;
        side_t   side;
    } div_res_t;

endpackage

### sv/cbw_ifs.sv
// request and result channels of the confined barycentric weights block
interface cbw_in_if;
    logic               valid;
    logic               ready;
    cbw_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cbw_out_if;
    logic               valid;
    logic               ready;
    cbw_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### sv/cbw_front.sv
// edge vectors, per-axis products and dot products, three stages
module cbw_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  cbw_pkg::in_item_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output cbw_pkg::dot_set_t dn_data
);

    localparam int STAGES = 3;
    localparam int NVEC   = 5;
    // vectors: e1, e2, q, qb, qc
    localparam int PAIR_L [cbw_pkg::NDOT] = '{0, 0, 1, 2, 2, 2, 3, 4};
    localparam int PAIR_R [cbw_pkg::NDOT] = '{0, 1, 1, 0, 1, 2, 3, 4};

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_in;
    logic [STAGES-1:0] adv;

    cbw_pkg::coord_t pt [3];
    cbw_pkg::coord_t ca [3];
    cbw_pkg::coord_t cb [3];
    cbw_pkg::coord_t cc [3];

    cbw_pkg::diff_t d_next [NVEC][3];
    cbw_pkg::diff_t d_reg  [NVEC][3];
    cbw_pkg::prod_t prod_reg [cbw_pkg::NDOT][3];
    cbw_pkg::dot_t  dot_reg  [cbw_pkg::NDOT];

    assign pt[0] = up_data.point_x;
    assign pt[1] = up_data.point_y;
    assign pt[2] = up_data.point_z;
    assign ca[0] = up_data.corner_a_x;
    assign ca[1] = up_data.corner_a_y;
    assign ca[2] = up_data.corner_a_z;
    assign cb[0] = up_data.corner_b_x;
    assign cb[1] = up_data.corner_b_y;
    assign cb[2] = up_data.corner_b_z;
    assign cc[0] = up_data.corner_c_x;
    assign cc[1] = up_data.corner_c_y;
    assign cc[2] = up_data.corner_c_z;

    assign adv[2]   = !vld_reg[2] || dn_ready;
    assign adv[1]   = !vld_reg[1] || adv[2];
    assign adv[0]   = !vld_reg[0] || adv[1];
    assign vld_in   = {vld_reg[STAGES-2:0], up_valid};
    assign up_ready = adv[0];
    assign dn_valid = vld_reg[STAGES-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d_next[0][i] = cbw_pkg::diff_t'(cb[i]) - cbw_pkg::diff_t'(ca[i]);
            d_next[1][i] = cbw_pkg::diff_t'(cc[i]) - cbw_pkg::diff_t'(ca[i]);
            d_next[2][i] = cbw_pkg::diff_t'(pt[i]) - cbw_pkg::diff_t'(ca[i]);
            d_next[3][i] = cbw_pkg::diff_t'(pt[i]) - cbw_pkg::diff_t'(cb[i]);
            d_next[4][i] = cbw_pkg::diff_t'(pt[i]) - cbw_pkg::diff_t'(cc[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            d_reg <= d_next;
        end
    end

    for (genvar k = 0; k < cbw_pkg::NDOT; k++)
    begin : g_dot
        always_ff @(posedge clk)
        begin
            if (adv[1])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[k][i] <= d_reg[PAIR_L[k]][i] * d_reg[PAIR_R[k]][i];
                end
            end
            if (adv[2])
            begin
                dot_reg[k] <= cbw_pkg::DOT_W'(prod_reg[k][0])
                            + cbw_pkg::DOT_W'(prod_reg[k][1])
                            + cbw_pkg::DOT_W'(prod_reg[k][2]);
            end
        end
        assign dn_data[k] = dot_reg[k];
    end

endmodule

### sv/cbw_wide.sv
// wide products, determinant, numerators and region selection, seven stages
module cbw_wide (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  cbw_pkg::dot_set_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output cbw_pkg::div_req_t dn_data
);

    localparam int STAGES = 7;
    localparam int NPROD  = 6;
    // products: s11*s22, s12*s12, s22*t1, s12*t2, s11*t2, s12*t1
    localparam int PROD_L [NPROD] = '{cbw_pkg::DOT_S11, cbw_pkg::DOT_S12, cbw_pkg::DOT_S22,
                                      cbw_pkg::DOT_S12, cbw_pkg::DOT_S11, cbw_pkg::DOT_S12};
    localparam int PROD_R [NPROD] = '{cbw_pkg::DOT_S22, cbw_pkg::DOT_S12, cbw_pkg::DOT_T1,
                                      cbw_pkg::DOT_T2, cbw_pkg::DOT_T2, cbw_pkg::DOT_T1};
    localparam int HW = cbw_pkg::HALF_W;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_in;
    logic [STAGES-1:0] adv;

    cbw_pkg::dot_t  dot_in [cbw_pkg::NDOT];
    cbw_pkg::dmag_t dmag   [cbw_pkg::NDOT];

    cbw_pkg::dmag_t  mag_reg  [NPROD][2];
    logic [NPROD-1:0] neg0_reg, neg1_reg, neg2_reg;
    cbw_pkg::pp_t    pp_reg   [NPROD][4];
    cbw_pkg::mag_t   pmag_reg [NPROD];
    cbw_pkg::wide_t  pval_reg [NPROD];
    cbw_pkg::near_t  near0_reg, near1_reg, near2_reg, near3_reg, near4_reg, near5_reg;
    cbw_pkg::near_t  near_next;
    cbw_pkg::wide_t  det4_reg, nb4_reg, nc4_reg;
    cbw_pkg::wide_t  det5_reg, nb5_reg, nc5_reg, na5_reg;
    logic            degen5_reg;
    cbw_pkg::div_req_t req_next, req_reg;
    logic            un, vn, wn;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_adv
        if (k == STAGES - 1)
        begin : g_last
            assign adv[k] = !vld_reg[k] || dn_ready;
        end
        else
        begin : g_mid
            assign adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign vld_in   = {vld_reg[STAGES-2:0], up_valid};
    assign up_ready = adv[0];
    assign dn_valid = vld_reg[STAGES-1];
    assign dn_data  = req_reg;

    always_comb
    begin
        for (int k = 0; k < cbw_pkg::NDOT; k++)
        begin
            dot_in[k] = up_data[k];
            dmag[k]   = dot_in[k][cbw_pkg::DOT_W-1] ? (~up_data[k] + cbw_pkg::DOT_W'(1))
                                                    : up_data[k];
        end
        near_next.a_wins = (dot_in[cbw_pkg::DOT_DA] < dot_in[cbw_pkg::DOT_DB])
                        && (dot_in[cbw_pkg::DOT_DA] < dot_in[cbw_pkg::DOT_DC]);
        near_next.b_wins = dot_in[cbw_pkg::DOT_DB] < dot_in[cbw_pkg::DOT_DC];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    // magnitudes, split products, signed recombination
    for (genvar p = 0; p < NPROD; p++)
    begin : g_prod
        always_ff @(posedge clk)
        begin
            if (adv[0])
            begin
                mag_reg[p][0] <= dmag[PROD_L[p]];
                mag_reg[p][1] <= dmag[PROD_R[p]];
                neg0_reg[p]   <= dot_in[PROD_L[p]][cbw_pkg::DOT_W-1]
                               ^ dot_in[PROD_R[p]][cbw_pkg::DOT_W-1];
            end
            if (adv[1])
            begin
                pp_reg[p][0] <= mag_reg[p][0][HW-1:0] * mag_reg[p][1][HW-1:0];
                pp_reg[p][1] <= mag_reg[p][0][HW-1:0] * mag_reg[p][1][2*HW-1:HW];
                pp_reg[p][2] <= mag_reg[p][0][2*HW-1:HW] * mag_reg[p][1][HW-1:0];
                pp_reg[p][3] <= mag_reg[p][0][2*HW-1:HW] * mag_reg[p][1][2*HW-1:HW];
                neg1_reg[p]  <= neg0_reg[p];
            end
            if (adv[2])
            begin
                pmag_reg[p] <= cbw_pkg::WIDE_W'(pp_reg[p][0])
                             + (cbw_pkg::WIDE_W'(pp_reg[p][1]) << HW)
                             + (cbw_pkg::WIDE_W'(pp_reg[p][2]) << HW)
                             + (cbw_pkg::WIDE_W'(pp_reg[p][3]) << (2 * HW));
                neg2_reg[p] <= neg1_reg[p];
            end
            if (adv[3])
            begin
                pval_reg[p] <= neg2_reg[p] ? (~pmag_reg[p] + cbw_pkg::WIDE_W'(1))
                                           : pmag_reg[p];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            near0_reg <= near_next;
        end
        if (adv[1])
        begin
            near1_reg <= near0_reg;
        end
        if (adv[2])
        begin
            near2_reg <= near1_reg;
        end
        if (adv[3])
        begin
            near3_reg <= near2_reg;
        end
        if (adv[4])
        begin
            det4_reg  <= pval_reg[0] - pval_reg[1];
            nb4_reg   <= pval_reg[2] - pval_reg[3];
            nc4_reg   <= pval_reg[4] - pval_reg[5];
            near4_reg <= near3_reg;
        end
        if (adv[5])
        begin
            det5_reg   <= det4_reg;
            nb5_reg    <= nb4_reg;
            nc5_reg    <= nc4_reg;
            na5_reg    <= det4_reg - nb4_reg - nc4_reg;
            degen5_reg <= cbw_pkg::mag_t'(det4_reg) <= cbw_pkg::DEGEN_LIMIT;
            near5_reg  <= near4_reg;
        end
        if (adv[6])
        begin
            req_reg <= req_next;
        end
    end

    assign un = na5_reg[cbw_pkg::WIDE_W-1];
    assign vn = nb5_reg[cbw_pkg::WIDE_W-1];
    assign wn = nc5_reg[cbw_pkg::WIDE_W-1];

    always_comb
    begin
        req_next             = '0;
        req_next.den         = '1;
        req_next.side.region = cbw_pkg::REG_INSIDE;
        priority if (degen5_reg)
        begin
            req_next.side.region = cbw_pkg::REG_DEGEN;
            priority if (near5_reg.a_wins)
            begin
                req_next.side.fix_a = cbw_pkg::WT_ONE;
            end
            else if (near5_reg.b_wins)
            begin
                req_next.side.fix_b = cbw_pkg::WT_ONE;
            end
            else
            begin
                req_next.side.fix_c = cbw_pkg::WT_ONE;
            end
        end
        else if (un && vn)
        begin
            req_next.side.region = cbw_pkg::REG_VERT_C;
            req_next.side.fix_c  = cbw_pkg::WT_ONE;
        end
        else if (un && wn)
        begin
            req_next.side.region = cbw_pkg::REG_VERT_B;
            req_next.side.fix_b  = cbw_pkg::WT_ONE;
        end
        else if (vn && wn)
        begin
            req_next.side.region = cbw_pkg::REG_VERT_A;
            req_next.side.fix_a  = cbw_pkg::WT_ONE;
        end
        else if (un)
        begin
            req_next.side.region = cbw_pkg::REG_EDGE_BC;
            req_next.num0        = nb5_reg;
            req_next.num1        = nc5_reg;
            req_next.den         = nb5_reg + nc5_reg;
        end
        else if (vn)
        begin
            req_next.side.region = cbw_pkg::REG_EDGE_AC;
            req_next.num0        = na5_reg;
            req_next.num1        = nc5_reg;
            req_next.den         = na5_reg + nc5_reg;
        end
        else if (wn)
        begin
            req_next.side.region = cbw_pkg::REG_EDGE_AB;
            req_next.num0        = na5_reg;
            req_next.num1        = nb5_reg;
            req_next.den         = na5_reg + nb5_reg;
        end
        else
        begin
            req_next.num0 = nb5_reg;
            req_next.num1 = nc5_reg;
            req_next.den  = det5_reg;
        end
    end

endmodule

### sv/cbw_div.sv
// two-lane restoring divider, one quotient bit per stage
module cbw_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  cbw_pkg::div_req_t up_data,
    output logic              dn_valid,
    input  logic              dn_ready,
    output cbw_pkg::div_res_t dn_data
);

    localparam int STAGES = cbw_pkg::WT_W;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_in;
    logic [STAGES-1:0] adv;

    cbw_pkg::mag_t    rem_reg  [STAGES][2];
    cbw_pkg::weight_t quot_reg [STAGES][2];
    cbw_pkg::mag_t    den_reg  [STAGES];
    cbw_pkg::side_t   side_reg [STAGES];

    assign vld_in   = {vld_reg[STAGES-2:0], up_valid};
    assign up_ready = adv[0];
    assign dn_valid = vld_reg[STAGES-1];
    assign dn_data  = '{quot0: quot_reg[STAGES-1][0], quot1: quot_reg[STAGES-1][1],
                        side: side_reg[STAGES-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
        end
    end

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        cbw_pkg::mag_t    rem_in  [2];
        cbw_pkg::weight_t quot_in [2];
        cbw_pkg::mag_t    den_in;
        cbw_pkg::side_t   side_in;
        logic [1:0]       take;

        if (k == STAGES - 1)
        begin : g_last
            assign adv[k] = !vld_reg[k] || dn_ready;
        end
        else
        begin : g_mid
            assign adv[k] = !vld_reg[k] || adv[k+1];
        end

        if (k == 0)
        begin : g_first
            assign rem_in[0]  = up_data.num0;
            assign rem_in[1]  = up_data.num1;
            assign quot_in[0] = '0;
            assign quot_in[1] = '0;
            assign den_in     = up_data.den;
            assign side_in    = up_data.side;
        end
        else
        begin : g_next
            assign rem_in[0]  = rem_reg[k-1][0] << 1;
            assign rem_in[1]  = rem_reg[k-1][1] << 1;
            assign quot_in[0] = quot_reg[k-1][0];
            assign quot_in[1] = quot_reg[k-1][1];
            assign den_in     = den_reg[k-1];
            assign side_in    = side_reg[k-1];
        end

        assign take[0] = rem_in[0] >= den_in;
        assign take[1] = rem_in[1] >= den_in;

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                for (int j = 0; j < 2; j++)
                begin
                    rem_reg[k][j]  <= take[j] ? (rem_in[j] - den_in) : rem_in[j];
                    quot_reg[k][j] <= {quot_in[j][cbw_pkg::WT_W-2:0], take[j]};
                end
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

endmodule

### sv/confined_barycentric_weights_top.sv
// top level of the confined barycentric weights block
// Takes one point and triangle request per clock unless back-pressure from the output stalls
// it, and returns one weight result per request, in order: 3 stages form the edge vectors and
// dot products, 7 stages build the 104-bit determinant and numerators from 26x26 partial
// products and pick the region, 17 stages of restoring division produce one quotient bit each
// for both weights, and one output register assembles the result. The 17-stage divider is
// the deepest section. Every stage advances whenever it is empty or its successor moves, so
// empty stages keep taking requests while a finished result waits at the output.
module confined_barycentric_weights_top (
    input logic      clk,
    input logic      rst_n,
    cbw_in_if.sink   query,
    cbw_out_if.source result
);

    logic              dot_valid, dot_ready;
    cbw_pkg::dot_set_t dot_data;
    logic              req_valid, req_ready;
    cbw_pkg::div_req_t req_data;
    logic              div_valid, div_ready;
    cbw_pkg::div_res_t div_data;

    logic               out_vld_reg;
    cbw_pkg::out_item_t out_reg, out_next;

    cbw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (query.valid),
        .up_ready (query.ready),
        .up_data  (query.data),
        .dn_valid (dot_valid),
        .dn_ready (dot_ready),
        .dn_data  (dot_data)
    );

    cbw_wide u_wide (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (dot_valid),
        .up_ready (dot_ready),
        .up_data  (dot_data),
        .dn_valid (req_valid),
        .dn_ready (req_ready),
        .dn_data  (req_data)
    );

    cbw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (req_valid),
        .up_ready (req_ready),
        .up_data  (req_data),
        .dn_valid (div_valid),
        .dn_ready (div_ready),
        .dn_data  (div_data)
    );

    assign div_ready    = !out_vld_reg || result.ready;
    assign result.valid = out_vld_reg;
    assign result.data  = out_reg;

    always_comb
    begin
        out_next.region = div_data.side.region;
        unique case (div_data.side.region)
            cbw_pkg::REG_INSIDE:
            begin
                out_next.weight_a = cbw_pkg::WT_ONE - div_data.quot0 - div_data.quot1;
                out_next.weight_b = div_data.quot0;
                out_next.weight_c = div_data.quot1;
            end
            cbw_pkg::REG_EDGE_BC:
            begin
                out_next.weight_a = '0;
                out_next.weight_b = div_data.quot0;
                out_next.weight_c = div_data.quot1;
            end
            cbw_pkg::REG_EDGE_AC:
            begin
                out_next.weight_a = div_data.quot0;
                out_next.weight_b = '0;
                out_next.weight_c = div_data.quot1;
            end
            cbw_pkg::REG_EDGE_AB:
            begin
                out_next.weight_a = div_data.quot0;
                out_next.weight_b = div_data.quot1;
                out_next.weight_c = '0;
            end
            default:
            begin
                out_next.weight_a = div_data.side.fix_a;
                out_next.weight_b = div_data.side.fix_b;
                out_next.weight_c = div_data.side.fix_c;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (div_ready)
        begin
            out_vld_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready && div_valid)
        begin
            out_reg <= out_next;
        end
    end

    // inside results sum to exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && (result.data.region == cbw_pkg::REG_INSIDE)) |->
        (({2'b00, result.data.weight_a} + {2'b00, result.data.weight_b}
          + {2'b00, result.data.weight_c}) == {2'b00, cbw_pkg::WT_ONE}))
        else $error("inside weights do not sum to one");

    // snapped and degenerate results put all weight on a single corner
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && ((result.data.region == cbw_pkg::REG_VERT_A)
                       || (result.data.region == cbw_pkg::REG_VERT_B)
                       || (result.data.region == cbw_pkg::REG_VERT_C)
                       || (result.data.region == cbw_pkg::REG_DEGEN))) |->
        ($onehot({result.data.weight_a == cbw_pkg::WT_ONE,
                  result.data.weight_b == cbw_pkg::WT_ONE,
                  result.data.weight_c == cbw_pkg::WT_ONE})
         && ($countones({result.data.weight_a != '0, result.data.weight_b != '0,
                         result.data.weight_c != '0}) == 1)))
        else $error("corner result is not a single unit weight");

    // edge results have the opposite corner weight zeroed
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
        (((result.data.region != cbw_pkg::REG_EDGE_BC) || (result.data.weight_a == '0))
         && ((result.data.region != cbw_pkg::REG_EDGE_AC) || (result.data.weight_b == '0))
         && ((result.data.region != cbw_pkg::REG_EDGE_AB) || (result.data.weight_c == '0))))
        else $error("edge result carries weight on the dropped corner");

endmodule

### sim/tb_top.sv
// testbench for the confined barycentric weights block: directed table, then random requests
`timescale 1ns / 1ps

module tb_top;
    import cbw_pkg::*;

    typedef logic signed [191:0] big_t;

    typedef struct {
        in_item_t  item;
        bit        typed;
        out_item_t want;
    } vec_row_t;

    localparam int N_RANDOM   = 1750;
    localparam int STALL_MAX  = 5000;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 40;

    logic clk;
    logic rst_n;

    cbw_in_if  query_ch ();
    cbw_out_if result_ch ();

    confined_barycentric_weights_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .result (result_ch)
    );

    out_item_t weights_due[$];
    vec_row_t  vec_rows[$];
    int        errors;
    int        sent;
    int        idle_cycles;
    logic      rx_hold;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic big_t dot3(big_t x0, big_t x1, big_t x2, big_t y0, big_t y1, big_t y2);
        return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    function automatic out_item_t predict_weights(in_item_t it);
        big_t p[3], a[3], b[3], c[3], e1[3], e2[3], q[3], qb[3], qc[3];
        big_t s11, s12, s22, t1, t2, det, nb, nc, na, da, db, dc, sum, one_b;
        out_item_t r;
        one_b = big_t'(65536);
        p[0] = it.point_x;    p[1] = it.point_y;    p[2] = it.point_z;
        a[0] = it.corner_a_x; a[1] = it.corner_a_y; a[2] = it.corner_a_z;
        b[0] = it.corner_b_x; b[1] = it.corner_b_y; b[2] = it.corner_b_z;
        c[0] = it.corner_c_x; c[1] = it.corner_c_y; c[2] = it.corner_c_z;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = b[i] - a[i];
            e2[i] = c[i] - a[i];
            q[i]  = p[i] - a[i];
            qb[i] = p[i] - b[i];
            qc[i] = p[i] - c[i];
        end
        s11 = dot3(e1[0], e1[1], e1[2], e1[0], e1[1], e1[2]);
        s12 = dot3(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2]);
        s22 = dot3(e2[0], e2[1], e2[2], e2[0], e2[1], e2[2]);
        t1  = dot3(q[0], q[1], q[2], e1[0], e1[1], e1[2]);
        t2  = dot3(q[0], q[1], q[2], e2[0], e2[1], e2[2]);
        det = s11 * s22 - s12 * s12;
        r.weight_a = '0;
        r.weight_b = '0;
        r.weight_c = '0;
        if (det * big_t'(100000) < (big_t'(1) <<< (4 * COORD_FRAC_BITS)))
        begin
            da = dot3(q[0], q[1], q[2], q[0], q[1], q[2]);
            db = dot3(qb[0], qb[1], qb[2], qb[0], qb[1], qb[2]);
            dc = dot3(qc[0], qc[1], qc[2], qc[0], qc[1], qc[2]);
            r.region = REG_DEGEN;
            if (da < db && da < dc)
                r.weight_a = WT_ONE;
            else if (db < dc)
                r.weight_b = WT_ONE;
            else
                r.weight_c = WT_ONE;
            return r;
        end
        nb = s22 * t1 - s12 * t2;
        nc = s11 * t2 - s12 * t1;
        na = det - nb - nc;
        if (na < 0 && nb < 0)
        begin
            r.region = REG_VERT_C;
            r.weight_c = WT_ONE;
        end
        else if (na < 0 && nc < 0)
        begin
            r.region = REG_VERT_B;
            r.weight_b = WT_ONE;
        end
        else if (nb < 0 && nc < 0)
        begin
            r.region = REG_VERT_A;
            r.weight_a = WT_ONE;
        end
        else if (na < 0)
        begin
            sum = nb + nc;
            r.region = REG_EDGE_BC;
            r.weight_b = weight_t'((nb * one_b) / sum);
            r.weight_c = weight_t'((nc * one_b) / sum);
        end
        else if (nb < 0)
        begin
            sum = na + nc;
            r.region = REG_EDGE_AC;
            r.weight_a = weight_t'((na * one_b) / sum);
            r.weight_c = weight_t'((nc * one_b) / sum);
        end
        else if (nc < 0)
        begin
            sum = na + nb;
            r.region = REG_EDGE_AB;
            r.weight_a = weight_t'((na * one_b) / sum);
            r.weight_b = weight_t'((nb * one_b) / sum);
        end
        else
        begin
            r.region = REG_INSIDE;
            r.weight_b = weight_t'((nb * one_b) / det);
            r.weight_c = weight_t'((nc * one_b) / det);
            r.weight_a = WT_ONE - r.weight_b - r.weight_c;
        end
        return r;
    endfunction

    function automatic in_item_t make_query(int px, int py, int pz, int ax, int ay, int az,
                                            int bx, int by, int bz, int cx, int cy, int cz);
        in_item_t it;
        it.point_x    = coord_t'(px); it.point_y    = coord_t'(py); it.point_z    = coord_t'(pz);
        it.corner_a_x = coord_t'(ax); it.corner_a_y = coord_t'(ay); it.corner_a_z = coord_t'(az);
        it.corner_b_x = coord_t'(bx); it.corner_b_y = coord_t'(by); it.corner_b_z = coord_t'(bz);
        it.corner_c_x = coord_t'(cx); it.corner_c_y = coord_t'(cy); it.corner_c_z = coord_t'(cz);
        return it;
    endfunction

    function automatic out_item_t make_weights(weight_t wa, weight_t wb, weight_t wc,
                                               region_t reg_code);
        out_item_t r;
        r.weight_a = wa;
        r.weight_b = wb;
        r.weight_c = wc;
        r.region   = reg_code;
        return r;
    endfunction

    function automatic void add_row(in_item_t it, bit typed, out_item_t want);
        vec_row_t row;
        row.item  = it;
        row.typed = typed;
        row.want  = want;
        vec_rows.push_back(row);
    endfunction

    function automatic int pick_extreme();
        case ($urandom_range(0, 5))
            0: return -8388608;
            1: return 8388607;
            2: return 0;
            3: return -1;
            4: return 1;
            default: return int'($urandom);
        endcase
    endfunction

    function automatic in_item_t random_query();
        int v[12];
        int base, span, d[3];
        int mode;
        mode = $urandom_range(0, 9);
        base = $urandom_range(0, 1) ? int'($urandom) >>> 9 : 0;
        span = $urandom_range(2, 22);
        for (int i = 0; i < 12; i++)
            v[i] = base + $signed($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
        for (int i = 0; i < 3; i++)
            d[i] = 2 * ($signed($urandom_range(0, (1 << (span - 1)))) - (1 << (span - 2)));
        case (mode)
            0, 1:
                for (int i = 0; i < 12; i++)
                    v[i] = int'($urandom);
            7:
            begin
                // collinear or collapsed corners
                for (int i = 0; i < 3; i++)
                begin
                    v[6 + i] = v[3 + i] + d[i];
                    v[9 + i] = v[3 + i] + $urandom_range(0, 3) * d[i];
                end
            end
            8:
            begin
                // line triangle with point equally far from b and c
                for (int i = 0; i < 3; i++)
                begin
                    v[6 + i] = v[3 + i] + d[i];
                    v[9 + i] = v[3 + i] + 2 * d[i];
                    v[i]     = v[3 + i] + d[i] + d[i] / 2;
                end
            end
            9:
                for (int i = 0; i < 12; i++)
                    v[i] = pick_extreme();
            default: ;
        endcase
        return make_query(v[0], v[1], v[2], v[3], v[4], v[5],
                          v[6], v[7], v[8], v[9], v[10], v[11]);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 7)
            return 0;
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    task automatic send_query(in_item_t it, out_item_t want);
        query_ch.valid <= 1'b1;
        query_ch.data  <= it;
        @(posedge clk);
        while (!query_ch.ready)
            @(posedge clk);
        weights_due.push_back(want);
        sent++;
    endtask

    task automatic pause_sender(int gap);
        if (gap > 0)
        begin
            query_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver side
    always @(posedge clk)
    begin
        out_item_t got, want;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.data;
                if (weights_due.size() == 0)
                begin
                    $display("result with no request waiting");
                    errors++;
                end
                else
                begin
                    want = weights_due.pop_front();
                    if (got.weight_a !== want.weight_a)
                        report_mismatch("weight_a", got.weight_a, want.weight_a);
                    if (got.weight_b !== want.weight_b)
                        report_mismatch("weight_b", got.weight_b, want.weight_b);
                    if (got.weight_c !== want.weight_c)
                        report_mismatch("weight_c", got.weight_c, want.weight_c);
                    if (got.region !== want.region)
                        report_mismatch("region", got.region, want.region);
                end
            end
            if (rx_hold)
                result_ch.ready <= 1'b0;
            else if (sent > 1200 && sent < 1400)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    // long receiver hold-off while requests keep coming
    initial
    begin
        rx_hold = 1'b0;
        @(posedge rst_n);
        while (sent < 500)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
        rx_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (query_ch.valid && query_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        in_item_t it;
        errors          = 0;
        sent            = 0;
        idle_cycles     = 0;
        rst_n           = 1'b0;
        query_ch.valid  = 1'b0;
        query_ch.data   = '0;
        result_ch.ready = 1'b0;

        add_row(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1,
                make_weights(0, 0, WT_ONE, REG_DEGEN));
        add_row(make_query(0, 0, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1,
                make_weights(WT_ONE, 0, 0, REG_INSIDE));
        add_row(make_query(4096, 0, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1,
                make_weights(0, WT_ONE, 0, REG_INSIDE));
        add_row(make_query(0, 8192, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1,
                make_weights(0, 0, WT_ONE, REG_EDGE_BC));
        add_row(make_query(-4096, -4096, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1,
                make_weights(WT_ONE, 0, 0, REG_VERT_A));
        add_row(make_query(8192, -4096, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 1,
                make_weights(0, WT_ONE, 0, REG_EDGE_AB));
        add_row(make_query(0, 0, 0, 0, 0, 0, 4096, 0, 0, 4096, 0, 0), 1,
                make_weights(WT_ONE, 0, 0, REG_DEGEN));
        add_row(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 4096, 0, 0), 1,
                make_weights(0, WT_ONE, 0, REG_DEGEN));
        add_row(make_query(1000, 1000, 7, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 0, '0);
        add_row(make_query(-3000, 5000, 9, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 0, '0);
        add_row(make_query(5000, -1000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0), 0, '0);
        add_row(make_query(8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                           8388607, -8388608, 0, -8388608, 8388607, 8388607), 0, '0);
        add_row(make_query(-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                           -8388608, 8388607, -1, 8388607, -8388608, 1), 0, '0);
        add_row(make_query(3, 1, 2, 1, 0, 0, 0, 1, 0, 0, 0, 1), 0, '0);
        add_row(make_query(6144, 0, 0, 0, 0, 0, 4096, 0, 0, 8192, 0, 0), 0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (vec_rows[i])
        begin
            send_query(vec_rows[i].item,
                       vec_rows[i].typed ? vec_rows[i].want : predict_weights(vec_rows[i].item));
            pause_sender(pick_gap());
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            it = random_query();
            send_query(it, predict_weights(it));
            if (n == 900)
            begin
                query_ch.valid <= 1'b0;
                while (weights_due.size() != 0)
                    @(posedge clk);
            end
            else if (n < 400 || n > 700)
                pause_sender(pick_gap());
        end
        query_ch.valid <= 1'b0;

        while (weights_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
sv/cbw_pkg.sv
sv/cbw_ifs.sv
sv/cbw_front.sv
sv/cbw_wide.sv
sv/cbw_div.sv
sv/confined_barycentric_weights_top.sv
sim/tb_top.sv
